@@ rtl/cts_pkg.sv @@
// shared constants and types for the 3x3 census transform stream
package cts_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int LINE_AW    = $clog2(MAX_WIDTH);
	localparam int PIX_W      = 8;
	localparam int ROW_W      = 12;
	localparam int COL_W      = 10;
	localparam int WIDTH_W    = 11;
	localparam int CFG_W      = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [ROW_W-1:0]   HEIGHT_RESET = 12'd480;

	// one stored line word: pixel of the row above and of the row two above
	typedef struct packed {
		logic [PIX_W-1:0] above;
		logic [PIX_W-1:0] two_above;
	} cts_line_t;

	// work handed from the counter stage to the window stage
	typedef struct packed {
		logic               valid;
		logic               upd;
		logic [PIX_W-1:0]   px;
		logic [COL_W-1:0]   addr;
		logic               emit_a;
		logic               emit_b;
		logic               interior;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col_a;
		logic               last;
	} cts_s1_t;

	// one result word
	typedef struct packed {
		logic [PIX_W-1:0] census_code;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic             frame_end;
	} cts_res_t;

endpackage

@@ rtl/cts_if.sv @@
// stream channel interfaces for pixel input and census output
interface cts_in_if;
	import cts_pkg::*;
	logic             valid;
	logic             ready;
	logic             mode;
	logic [PIX_W-1:0] pixel;

	modport source (output valid, output mode, output pixel, input ready);
	modport sink   (input valid, input mode, input pixel, output ready);
endinterface

interface cts_out_if;
	import cts_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] census_code;
	logic [ROW_W-1:0] out_row;
	logic [COL_W-1:0] out_col;
	logic             frame_end;

	modport source (output valid, output census_code, output out_row, output out_col,
		output frame_end, input ready);
	modport sink   (input valid, input census_code, input out_row, input out_col,
		input frame_end, output ready);
endinterface

@@ rtl/cts_line_ram.sv @@
// dual line store: one synchronous ram word per column, registered read
module cts_line_ram (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [cts_pkg::LINE_AW-1:0]   rd_addr,
	output cts_pkg::cts_line_t            rd_data,
	input  logic                          wr_en,
	input  logic [cts_pkg::LINE_AW-1:0]   wr_addr,
	input  cts_pkg::cts_line_t            wr_data
);
	import cts_pkg::*;

	cts_line_t mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

@@ rtl/cts_window.sv @@
// 3x3 window shift, line store write-back and census code forming
module cts_window (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cts_pkg::cts_s1_t     s1,
	input  cts_pkg::cts_line_t   rd_data,
	output logic                 wr_en,
	output logic [cts_pkg::LINE_AW-1:0] wr_addr,
	output cts_pkg::cts_line_t   wr_data,
	output logic                 push0,
	output logic                 push1,
	output cts_pkg::cts_res_t    res0,
	output cts_pkg::cts_res_t    res1
);
	import cts_pkg::*;

	// columns 1 and 2 of the window, index 0 is the top row
	logic [PIX_W-1:0] mid_q [3];
	logic [PIX_W-1:0] rgt_q [3];
	logic [PIX_W-1:0] centre;
	logic [PIX_W-1:0] code;
	logic             do_upd;

	assign do_upd  = s1.valid && s1.upd;
	assign wr_en   = do_upd;
	assign wr_addr = s1.addr[LINE_AW-1:0];
	assign wr_data = '{above: s1.px, two_above: rd_data.above};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				mid_q[i] <= '0;
				rgt_q[i] <= '0;
			end
		end else if (do_upd) begin
			for (int i = 0; i < 3; i++) begin
				mid_q[i] <= rgt_q[i];
			end
			rgt_q[0] <= rd_data.two_above;
			rgt_q[1] <= rd_data.above;
			rgt_q[2] <= s1.px;
		end
	end

	// after the shift the centre is the old right-middle pixel
	assign centre = rgt_q[1];
	always_comb begin
		code[7] = centre >= mid_q[0];
		code[6] = centre >= rgt_q[0];
		code[5] = centre >= rd_data.two_above;
		code[4] = centre >= mid_q[1];
		code[3] = centre >= rd_data.above;
		code[2] = centre >= mid_q[2];
		code[1] = centre >= rgt_q[2];
		code[0] = centre >= s1.px;
	end

	assign push0 = s1.valid && s1.emit_a;
	assign push1 = s1.valid && s1.emit_b;

	always_comb begin
		res0.census_code = (s1.upd && s1.interior) ? code : '0;
		res0.out_row     = s1.row;
		res0.out_col     = s1.col_a;
		res0.frame_end   = s1.last;
		res1.census_code = '0;
		res1.out_row     = s1.row;
		res1.out_col     = s1.addr;
		res1.frame_end   = 1'b0;
	end
endmodule

@@ rtl/cts_out_fifo.sv @@
// result word queue taking up to two words a cycle, giving one
module cts_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push0,
	input  logic              push1,
	input  cts_pkg::cts_res_t res0,
	input  cts_pkg::cts_res_t res1,
	output logic              room,
	output logic              valid,
	input  logic              ready,
	output cts_pkg::cts_res_t head
);
	import cts_pkg::*;

	cts_res_t           buf_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q;
	logic [FIFO_AW-1:0] rp_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic               pop;
	logic [FIFO_AW-1:0] wp1;
	logic [FIFO_CW-1:0] n_push;

	assign valid  = cnt_q != '0;
	assign pop    = valid && ready;
	assign head   = buf_q[rp_q];
	assign wp1    = wp_q + FIFO_AW'(1);
	assign n_push = FIFO_CW'(push0) + FIFO_CW'(push1);
	// one word may sit in the window stage and one be accepted now, two results each
	assign room   = cnt_q <= FIFO_CW'(FIFO_DEPTH - 4);

	always_ff @(posedge clk) begin
		if (push0) begin
			buf_q[wp_q] <= res0;
		end
		if (push1) begin
			buf_q[wp1] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + FIFO_AW'(n_push);
			rp_q  <= rp_q + FIFO_AW'(pop);
			cnt_q <= cnt_q + n_push - FIFO_CW'(pop);
		end
	end
endmodule

@@ rtl/census_transform_3x3_stream.sv @@
// 3x3 census transform stream, top level
// Takes an 8-bit image in raster order, one pixel word per cycle, and gives one
// census word per image position: bits 7 to 0 are set when the centre is greater
// than or equal to its NW, N, NE, W, E, SW, S and SE neighbour; border positions
// give code 0. Results trail the input by one row and one column. After the last
// pixel of a frame the block waits for flush words (mode 1), each of which gives
// one position of the bottom border row; the last one carries frame_end. Pixel
// words that arrive while flush words are due are taken and dropped, and flush
// words outside that window are taken and ignored. Sustained rate is one input
// word per clock while input ready is high: the two line stores share one ram word
// per column, read at acceptance and written back in the next cycle from the window
// stage, so the single read port and single write port of that ram set the figure. A
// pixel's results are registered in the window stage, then written into the output
// queue and held there until out_ch takes them; input ready falls only while the
// eight-word output queue holds more than four words.
// image_width is clamped to 3..1024 and image_height to at least 3; write them
// only while no word is in flight. The line ram needs no clearing after reset.
module census_transform_3x3_stream (
	input  logic                            clk,
	input  logic                            arst_n,
	cts_in_if.sink                          in_ch,
	cts_out_if.source                       out_ch,
	input  logic                            cfg_we,
	input  logic [cts_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [cts_pkg::CFG_W-1:0]       cfg_data
);
	import cts_pkg::*;

	// configuration
	logic [WIDTH_W-1:0] width_q;
	logic [ROW_W-1:0]   height_q;
	logic [WIDTH_W-1:0] w_eff;
	logic [COL_W-1:0]   wm1;
	logic [ROW_W-1:0]   hm1;

	// position counters
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [COL_W-1:0]   flush_q;
	logic               await_q;

	logic [ROW_W-1:0]   r;
	logic [COL_W-1:0]   c;
	logic [COL_W-1:0]   f;
	logic               is_pix;
	logic               accept;
	logic               act;
	logic               last_col;
	logic               last_flush;

	cts_s1_t            s1_d;
	cts_s1_t            s1_q;

	cts_line_t          rd_data;
	logic               wr_en;
	logic [LINE_AW-1:0] wr_addr;
	cts_line_t          wr_data;
	logic               push0;
	logic               push1;
	cts_res_t           res0;
	cts_res_t           res1;
	cts_res_t           head;
	logic               room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// effective geometry, last column and last row
	always_comb begin
		if (width_q < WIDTH_W'(3)) begin
			w_eff = WIDTH_W'(3);
		end else if (width_q > WIDTH_W'(MAX_WIDTH)) begin
			w_eff = WIDTH_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
	end
	assign wm1 = COL_W'(w_eff - WIDTH_W'(1));
	assign hm1 = (height_q < ROW_W'(3)) ? ROW_W'(2) : height_q - ROW_W'(1);

	// counters beyond the limits sit on the last row or column
	assign r = (row_q > hm1) ? hm1 : row_q;
	assign c = (col_q > wm1) ? wm1 : col_q;
	assign f = (flush_q > wm1) ? wm1 : flush_q;

	assign in_ch.ready = room;
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_pix      = in_ch.mode == MODE_PIXEL;
	// a pixel needs the frame open, a flush needs it closed
	assign act         = accept && (is_pix ? !await_q : await_q);
	assign last_col    = c == wm1;
	assign last_flush  = f == wm1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			flush_q <= '0;
			await_q <= 1'b0;
		end else if (act) begin
			if (!is_pix) begin
				if (last_flush) begin
					flush_q <= '0;
					row_q   <= '0;
					col_q   <= '0;
					await_q <= 1'b0;
				end else begin
					flush_q <= f + COL_W'(1);
				end
			end else if (last_col) begin
				col_q <= '0;
				if (r == hm1) begin
					row_q   <= r;
					await_q <= 1'b1;
					flush_q <= '0;
				end else begin
					row_q <= r + ROW_W'(1);
				end
			end else begin
				col_q <= c + COL_W'(1);
				row_q <= r;
			end
		end
	end

	// work for the window stage
	always_comb begin
		s1_d.valid    = act;
		s1_d.upd      = is_pix;
		s1_d.px       = in_ch.pixel;
		s1_d.addr     = c;
		s1_d.emit_a   = is_pix ? (r != '0 && c != '0) : 1'b1;
		s1_d.emit_b   = is_pix && r != '0 && last_col;
		s1_d.interior = r >= ROW_W'(2) && c >= COL_W'(2);
		s1_d.row      = is_pix ? r - ROW_W'(1) : hm1;
		s1_d.col_a    = is_pix ? c - COL_W'(1) : f;
		s1_d.last     = !is_pix && last_flush;
	end

	// window stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
		end else begin
			s1_q <= s1_d;
		end
	end

	// line ram read at acceptance; consecutive columns never collide with the write-back
	cts_line_ram u_line_ram (
		.clk     (clk),
		.rd_en   (act && is_pix),
		.rd_addr (c[LINE_AW-1:0]),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	cts_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.s1      (s1_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.push0   (push0),
		.push1   (push1),
		.res0    (res0),
		.res1    (res1)
	);

	cts_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push0  (push0),
		.push1  (push1),
		.res0   (res0),
		.res1   (res1),
		.room   (room),
		.valid  (out_ch.valid),
		.ready  (out_ch.ready),
		.head   (head)
	);

	assign out_ch.census_code = head.census_code;
	assign out_ch.out_row     = head.out_row;
	assign out_ch.out_col     = head.out_col;
	assign out_ch.frame_end   = head.frame_end;
endmodule
